// File: rtl/modbus_read_coils_frame_check_defines.svh
// Assertion macros for the frame checker, included by the frame core module.
`ifndef MODBUS_READ_COILS_FRAME_CHECK_DEFINES_SVH
`define MODBUS_READ_COILS_FRAME_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define MBRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define MBRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mbrc_pkg.sv
// Types, constants and the CRC function of the read-coils frame checker.
package mbrc_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FN_READ_COILS = 8'h01;
  localparam logic [2:0]  CRC_SPAN      = 3'd6;

  localparam logic [2:0] POS_ID      = 3'd0;
  localparam logic [2:0] POS_FN      = 3'd1;
  localparam logic [2:0] POS_ADDR_HI = 3'd2;
  localparam logic [2:0] POS_ADDR_LO = 3'd3;
  localparam logic [2:0] POS_QTY_HI  = 3'd4;
  localparam logic [2:0] POS_QTY_LO  = 3'd5;
  localparam logic [2:0] POS_CRC_1ST = 3'd6;
  localparam logic [2:0] POS_CRC_2ND = 3'd7;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_IGNORED  = 2'd2
  } mbrc_status_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] frame_byte;
    logic       frame_start;
  } mbrc_item_t;

  typedef struct packed {
    logic [7:0]   slave_id;
    logic [7:0]   function_code;
    logic [15:0]  start_address;
    logic [15:0]  coil_quantity;
    logic [15:0]  received_crc;
    mbrc_status_e frame_status;
  } mbrc_result_t;

  // One byte of CRC-16/MODBUS, reflected, processed LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/mbrc_if.sv
// Channel interfaces of the read-coils frame checker.
interface mbrc_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;
  modport source (output valid, frame_byte, frame_start, input ready);
  modport sink (input valid, frame_byte, frame_start, output ready);
endinterface

interface mbrc_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slave_id;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [15:0] coil_quantity;
  logic [15:0] received_crc;
  logic [1:0]  frame_status;
  modport source (output valid, slave_id, function_code, start_address, coil_quantity,
                  received_crc, frame_status, input ready);
  modport sink (input valid, slave_id, function_code, start_address, coil_quantity,
                received_crc, frame_status, output ready);
endinterface

interface mbrc_cfg_if;
  logic valid;
  logic ready;
  logic crc_high_first;
  modport source (output valid, crc_high_first, input ready);
  modport sink (input valid, crc_high_first, output ready);
endinterface

// File: rtl/mbrc_in_stage.sv
// Input register that holds one received byte until the frame core takes it.
module mbrc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  mbrc_frame_if.sink          frame_i,
  input  logic                take_i,
  output mbrc_pkg::mbrc_item_t item_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       start_q;
  logic       accept;

  assign frame_i.ready = !valid_q || take_i;
  assign accept        = frame_i.valid && frame_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= frame_i.frame_byte;
      start_q <= frame_i.frame_start;
    end
  end

  assign item_o.valid       = valid_q;
  assign item_o.frame_byte  = byte_q;
  assign item_o.frame_start = start_q;

endmodule

// File: rtl/mbrc_frame_core.sv
// Frame position counter, running CRC, held fields and result decode.
`include "modbus_read_coils_frame_check_defines.svh"

module mbrc_frame_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mbrc_cfg_if.sink              cfg_i,
  input  mbrc_pkg::mbrc_item_t  item_i,
  input  logic                  out_free_i,
  output logic                  take_o,
  output logic                  res_load_o,
  output mbrc_pkg::mbrc_result_t res_o
);

  logic        high_first_q;
  logic [15:0] crc_q, crc_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  fn_q, fn_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] qty_q, qty_d;
  logic [7:0]  crc1_q, crc1_d;

  logic [2:0]  pos;
  logic [15:0] crc_base;
  logic [15:0] crc_upd;
  logic        last;
  logic [7:0]  b;
  logic [15:0] rx;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_first_q <= 1'b1;
    end else if (cfg_i.valid) begin
      high_first_q <= cfg_i.crc_high_first;
    end
  end

  assign b        = item_i.frame_byte;
  assign pos      = item_i.frame_start ? mbrc_pkg::POS_ID : pos_q;
  assign crc_base = item_i.frame_start ? mbrc_pkg::CRC_INIT : crc_q;
  assign crc_upd  = mbrc_pkg::crc16_byte(crc_base, b);
  assign last     = (pos == mbrc_pkg::POS_CRC_2ND);

  assign take_o     = item_i.valid && (!last || out_free_i);
  assign res_load_o = item_i.valid && last && out_free_i;

  assign rx = high_first_q ? {crc1_q, b} : {b, crc1_q};

  always_comb begin
    res_o.slave_id      = id_q;
    res_o.function_code = fn_q;
    res_o.start_address = addr_q;
    res_o.coil_quantity = qty_q;
    res_o.received_crc  = rx;
    if (fn_q != mbrc_pkg::FN_READ_COILS) begin
      res_o.frame_status = mbrc_pkg::ST_IGNORED;
    end else if (rx == crc_base) begin
      res_o.frame_status = mbrc_pkg::ST_VALID;
    end else begin
      res_o.frame_status = mbrc_pkg::ST_CRC_ERR;
    end
  end

  always_comb begin
    crc_d  = crc_q;
    pos_d  = pos_q;
    id_d   = id_q;
    fn_d   = fn_q;
    addr_d = addr_q;
    qty_d  = qty_q;
    crc1_d = crc1_q;
    if (take_o) begin
      pos_d = pos + 3'd1;
      if (last) begin
        crc_d = mbrc_pkg::CRC_INIT;
      end else if (pos < mbrc_pkg::CRC_SPAN) begin
        crc_d = crc_upd;
      end else begin
        crc_d = crc_base;
      end
      unique case (pos)
        mbrc_pkg::POS_ID:      id_d   = b;
        mbrc_pkg::POS_FN:      fn_d   = b;
        mbrc_pkg::POS_ADDR_HI: addr_d = {b, 8'h00};
        mbrc_pkg::POS_ADDR_LO: addr_d = {addr_q[15:8], b};
        mbrc_pkg::POS_QTY_HI:  qty_d  = {b, 8'h00};
        mbrc_pkg::POS_QTY_LO:  qty_d  = {qty_q[15:8], b};
        mbrc_pkg::POS_CRC_1ST: crc1_d = b;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= mbrc_pkg::CRC_INIT;
      pos_q  <= mbrc_pkg::POS_ID;
      id_q   <= '0;
      fn_q   <= '0;
      addr_q <= '0;
      qty_q  <= '0;
      crc1_q <= '0;
    end else begin
      crc_q  <= crc_d;
      pos_q  <= pos_d;
      id_q   <= id_d;
      fn_q   <= fn_d;
      addr_q <= addr_d;
      qty_q  <= qty_d;
      crc1_q <= crc1_d;
    end
  end

  `MBRC_ASSERT_IMP(a_result_only_at_end, res_load_o,
                   (pos_q == mbrc_pkg::POS_CRC_2ND) && !item_i.frame_start,
                   "Result produced away from the last byte of a frame.")
  `MBRC_ASSERT_NXT(a_restart_after_end, take_o && last,
                   (crc_q == mbrc_pkg::CRC_INIT) && (pos_q == mbrc_pkg::POS_ID),
                   "Frame state did not restart after the last byte.")
  `MBRC_ASSERT_NXT(a_start_resyncs, take_o && item_i.frame_start,
                   pos_q == mbrc_pkg::POS_FN,
                   "A start-marked item did not become byte zero.")

endmodule

// File: rtl/mbrc_out_reg.sv
// Output register that holds one result item until the receiver takes it.
module mbrc_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  mbrc_pkg::mbrc_result_t res_i,
  output logic                   out_free_o,
  mbrc_result_if.source          result_o
);

  logic                   valid_q, valid_d;
  mbrc_pkg::mbrc_result_t res_q;

  assign out_free_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.slave_id      = res_q.slave_id;
  assign result_o.function_code = res_q.function_code;
  assign result_o.start_address = res_q.start_address;
  assign result_o.coil_quantity = res_q.coil_quantity;
  assign result_o.received_crc  = res_q.received_crc;
  assign result_o.frame_status  = res_q.frame_status;

endmodule

// File: rtl/modbus_read_coils_frame_check.sv
// Top level of the Modbus read-coils request frame checker.
//
// Bytes of an 8-byte request frame arrive on frame_i, one item per byte; frame_start
// marks byte zero and restarts the count and the CRC. Without the mark the count
// simply runs on and wraps after byte seven.
// After byte seven one result item leaves on result_o with the unit id, function
// code, start address, quantity, the received CRC and a status: valid read coils,
// read coils with a CRC error, or another function that is ignored.
// cfg_i writes the CRC byte order; 1 takes byte six as the high byte, 0 the low one.
// Each byte is registered on entry; the CRC update over eight bits and the field
// capture finish when the frame core takes it from that register. A result is
// loaded into the output register when the core takes its last byte. One byte is
// accepted per cycle, sustained, unless a final byte waits for the output register.
// Reset clears the count, sets the CRC to 0xFFFF, clears the held fields and sets
// the byte order to high first; both channel registers come up empty.
// When the receiver stalls, the finished result waits in the output register while
// the bytes before the final byte of the next frame keep flowing; only that final
// byte waits, and it holds the input until the output register is free.
module modbus_read_coils_frame_check (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbrc_frame_if.sink    frame_i,
  mbrc_cfg_if.sink      cfg_i,
  mbrc_result_if.source result_o
);

  mbrc_pkg::mbrc_item_t   item;
  mbrc_pkg::mbrc_result_t res;
  logic                   take;
  logic                   res_load;
  logic                   out_free;

  mbrc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_i),
    .take_i  (take),
    .item_o  (item)
  );

  mbrc_frame_core u_frame_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .item_i     (item),
    .out_free_i (out_free),
    .take_o     (take),
    .res_load_o (res_load),
    .res_o      (res)
  );

  mbrc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_load),
    .res_i      (res),
    .out_free_o (out_free),
    .result_o   (result_o)
  );

endmodule

// File: test/tb.sv
// Testbench for the Modbus read-coils frame checker, predicting and checking each result item.
`timescale 1ns / 100ps

module tb;

  logic clk;
  logic rst_n;

  mbrc_frame_if  frame_ch ();
  mbrc_cfg_if    cfg_ch ();
  mbrc_result_if res_ch ();

  modbus_read_coils_frame_check dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .frame_i  (frame_ch),
    .cfg_i    (cfg_ch),
    .result_o (res_ch)
  );

  mbrc_pkg::mbrc_result_t frames_due[$];
  int           err_count = 0;
  int           bytes_sent = 0;

  bit src_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;
  int sink_hold_cycles = 0;

  logic        cfg_high_first = 1'b1;
  logic [15:0] crc_acc = mbrc_pkg::CRC_INIT;
  logic [2:0]  frame_pos = mbrc_pkg::POS_ID;
  logic [7:0]  id_seen = 8'h00;
  logic [7:0]  fn_seen = 8'h00;
  logic [15:0] addr_seen = 16'h0000;
  logic [15:0] qty_seen = 16'h0000;
  logic [7:0]  crc_first_seen = 8'h00;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_error(input string msg);
    if (err_count < 100) $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_error($sformatf("%s is %04h, expected %04h", name, got, want));
  endtask

  function automatic logic [15:0] crc_after_byte(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ data[i]) ? ((r >> 1) ^ mbrc_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic track_frame_byte(input logic [7:0] data, input logic first);
    mbrc_pkg::mbrc_result_t r;
    if (first) begin
      frame_pos = mbrc_pkg::POS_ID;
      crc_acc = mbrc_pkg::CRC_INIT;
    end
    if (frame_pos < mbrc_pkg::CRC_SPAN) crc_acc = crc_after_byte(crc_acc, data);
    case (frame_pos)
      mbrc_pkg::POS_ID:      id_seen = data;
      mbrc_pkg::POS_FN:      fn_seen = data;
      mbrc_pkg::POS_ADDR_HI: addr_seen = {data, 8'h00};
      mbrc_pkg::POS_ADDR_LO: addr_seen[7:0] = data;
      mbrc_pkg::POS_QTY_HI:  qty_seen = {data, 8'h00};
      mbrc_pkg::POS_QTY_LO:  qty_seen[7:0] = data;
      mbrc_pkg::POS_CRC_1ST: crc_first_seen = data;
      default: begin
        r.slave_id = id_seen;
        r.function_code = fn_seen;
        r.start_address = addr_seen;
        r.coil_quantity = qty_seen;
        r.received_crc = cfg_high_first ? {crc_first_seen, data} : {data, crc_first_seen};
        if (fn_seen != mbrc_pkg::FN_READ_COILS) r.frame_status = mbrc_pkg::ST_IGNORED;
        else if (r.received_crc == crc_acc) r.frame_status = mbrc_pkg::ST_VALID;
        else r.frame_status = mbrc_pkg::ST_CRC_ERR;
        frames_due.push_back(r);
        crc_acc = mbrc_pkg::CRC_INIT;
      end
    endcase
    frame_pos = frame_pos + 3'd1;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic first);
    int gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.frame_byte <= data;
    frame_ch.frame_start <= first;
    do @(posedge clk); while (frame_ch.ready !== 1'b1);
    track_frame_byte(data, first);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] fn, input logic [15:0] addr,
                            input logic [15:0] qty, input bit crc_ok, input bit mark);
    logic [7:0]  bytes [8];
    logic [15:0] crc;
    bytes[0] = id;
    bytes[1] = fn;
    bytes[2] = addr[15:8];
    bytes[3] = addr[7:0];
    bytes[4] = qty[15:8];
    bytes[5] = qty[7:0];
    crc = mbrc_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc_after_byte(crc, bytes[i]);
    if (!crc_ok) crc = crc ^ 16'($urandom_range(1, 65535));
    if (cfg_high_first) begin
      bytes[6] = crc[15:8];
      bytes[7] = crc[7:0];
    end else begin
      bytes[6] = crc[7:0];
      bytes[7] = crc[15:8];
    end
    for (int i = 0; i < 8; i++) send_byte(bytes[i], (i == 0) && mark);
  endtask

  task automatic send_random_frame();
    logic [7:0] fn;
    bit         mark;
    fn = ($urandom_range(0, 9) < 8) ? mbrc_pkg::FN_READ_COILS : 8'($urandom_range(0, 255));
    mark = (frame_pos != mbrc_pkg::POS_ID) || ($urandom_range(0, 1) == 1);
    send_frame(8'($urandom_range(0, 255)), fn, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), $urandom_range(0, 99) < 70, mark);
  endtask

  task automatic send_fragment();
    int len;
    len = $urandom_range(1, 7);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)),
                (i == 0) ? $urandom_range(0, 1) == 1 : $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic drain_frames(input int settle);
    int waited;
    waited = 0;
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_byte_order(input logic high_first);
    drain_frames(6);
    cfg_ch.valid <= 1'b1;
    cfg_ch.crc_high_first <= high_first;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    cfg_high_first = high_first;
  endtask

  // Runs at the reset byte order: a good frame, an unmarked frame with a bad CRC,
  // then a partial frame cut off by a new start mark carrying another function.
  task automatic test_directed_frames();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    send_frame(8'h00, mbrc_pkg::FN_READ_COILS, 16'h0000, 16'hFFFF, 1'b1, 1'b1);
    send_frame(8'hFF, mbrc_pkg::FN_READ_COILS, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_byte(8'h11, 1'b1);
    send_byte(mbrc_pkg::FN_READ_COILS, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_frame(8'h5A, 8'hFF, 16'h1234, 16'h00FF, 1'b1, 1'b1);
  endtask

  task automatic test_low_first_order();
    set_byte_order(1'b0);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    send_frame(8'h01, mbrc_pkg::FN_READ_COILS, 16'h0013, 16'h0025, 1'b1, 1'b1);
    send_frame(8'h02, mbrc_pkg::FN_READ_COILS, 16'h8000, 16'h0001, 1'b0, 1'b1);
    repeat (3) send_random_frame();
  endtask

  task automatic test_backpressure();
    set_byte_order(1'b1);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    sink_hold_cycles = 150;
    repeat (6) send_random_frame();
    drain_frames(4);
  endtask

  task automatic test_random_traffic();
    int phase_start;
    for (int phase = 0; phase < 4; phase++) begin
      set_byte_order(phase[0]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 70) begin
        src_idle_on = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 99) < 85) send_random_frame();
        else send_fragment();
      end
    end
  endtask

  task automatic test_steady_stream();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    repeat (6) send_random_frame();
  endtask

  initial begin : result_pacing
    int n;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        n = sink_hold_cycles;
        sink_hold_cycles = 0;
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    mbrc_pkg::mbrc_result_t want;
    if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (frames_due.size() == 0) begin
        report_error($sformatf("result item with no frame pending, slave_id %02h",
                               res_ch.slave_id));
      end else begin
        want = frames_due.pop_front();
        check_field("slave_id", 16'(res_ch.slave_id), 16'(want.slave_id));
        check_field("function_code", 16'(res_ch.function_code), 16'(want.function_code));
        check_field("start_address", res_ch.start_address, want.start_address);
        check_field("coil_quantity", res_ch.coil_quantity, want.coil_quantity);
        check_field("received_crc", res_ch.received_crc, want.received_crc);
        check_field("frame_status", 16'(res_ch.frame_status), 16'(want.frame_status));
      end
    end
  end

  initial begin : main_flow
    frame_ch.valid <= 1'b0;
    frame_ch.frame_byte <= 8'h00;
    frame_ch.frame_start <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.crc_high_first <= 1'b1;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_low_first_order();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    drain_frames(8);
    if (frames_due.size() != 0) begin
      report_error($sformatf("%0d expected result items never arrived", frames_due.size()));
    end
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
